// ===== rtl/aescd_pkg.sv =====
// shared types, tables and field helpers for the aes-128 cbc/ctr decryptor
package aescd_pkg;

  localparam int KeyBits   = 128;
  localparam int NumRounds = KeyBits / 32 + 6;
  localparam int StepW     = $clog2(NumRounds + 1);

  localparam logic [1:0] CFG_MODE     = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [1:0] CFG_KEY_LOW  = 2'd2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic MODE_CBC  = 1'b0;

  typedef enum logic [1:0] {ST_IDLE, ST_EXPAND, ST_ROUNDS, ST_OUT} state_t;

  typedef struct packed {
    logic enc;
    logic skip_mix;
  } round_ctl_t;

  typedef logic [7:0] byte_tbl_t [256];

  localparam logic [2047:0] SBOX_BITS = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  function automatic byte_tbl_t build_fwd();
    byte_tbl_t t;
    for (int v = 0; v < 256; v++) begin
      t[v] = SBOX_BITS[2047 - 8 * v -: 8];
    end
    return t;
  endfunction

  function automatic byte_tbl_t build_inv();
    byte_tbl_t t;
    for (int v = 0; v < 256; v++) begin
      t[SBOX_BITS[2047 - 8 * v -: 8]] = 8'(v);
    end
    return t;
  endfunction

  localparam byte_tbl_t SBOX     = build_fwd();
  localparam byte_tbl_t INV_SBOX = build_inv();

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

// ===== rtl/aescd_key_step.sv =====
// one step of the aes-128 key schedule: next round key from the current one
module aescd_key_step (
  input  logic [127:0] key_in,
  input  logic [7:0]   rcon,
  output logic [127:0] key_out
);

  logic [31:0] t, w0, w1, w2, w3;

  always_comb begin
    t = {aescd_pkg::SBOX[key_in[23:16]] ^ rcon, aescd_pkg::SBOX[key_in[15:8]],
         aescd_pkg::SBOX[key_in[7:0]], aescd_pkg::SBOX[key_in[31:24]]};
    w0 = key_in[127:96] ^ t;
    w1 = key_in[95:64] ^ w0;
    w2 = key_in[63:32] ^ w1;
    w3 = key_in[31:0] ^ w2;
    key_out = {w0, w1, w2, w3};
  end

endmodule

// ===== rtl/aescd_round.sv =====
// shared aes round: forward or inverse, mix columns optional
module aescd_round (
  input  logic [127:0]           state_in,
  input  logic [127:0]           round_key,
  input  aescd_pkg::round_ctl_t  ctl,
  output logic [127:0]           state_out
);

  logic [7:0] s [16];
  logic [7:0] o [16];
  logic [7:0] m [16];
  logic [7:0] a0, a1, a2, a3;

  function automatic logic [7:0] mul_e(input logic [7:0] a, input logic [3:0] c);
    logic [7:0] x2, x4, x8, r;
    x2 = aescd_pkg::xt(a);
    x4 = aescd_pkg::xt(x2);
    x8 = aescd_pkg::xt(x4);
    r = 8'h00;
    if (c[0]) r = r ^ a;
    if (c[1]) r = r ^ x2;
    if (c[2]) r = r ^ x4;
    if (c[3]) r = r ^ x8;
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_in[127 - 8 * i -: 8];
    end
    // substitution and row shift (the inverse also adds the round key); byte i is row i%4, column i/4
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (ctl.enc) begin
          o[r + 4 * c] = aescd_pkg::SBOX[s[r + 4 * ((c + r) % 4)]];
        end else begin
          o[r + 4 * c] = aescd_pkg::INV_SBOX[s[r + 4 * ((c - r + 4) % 4)]]
                         ^ round_key[127 - 8 * (r + 4 * c) -: 8];
        end
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = o[4 * c];
      a1 = o[4 * c + 1];
      a2 = o[4 * c + 2];
      a3 = o[4 * c + 3];
      if (ctl.enc) begin
        m[4 * c]     = mul_e(a0, 4'd2) ^ mul_e(a1, 4'd3) ^ a2 ^ a3;
        m[4 * c + 1] = a0 ^ mul_e(a1, 4'd2) ^ mul_e(a2, 4'd3) ^ a3;
        m[4 * c + 2] = a0 ^ a1 ^ mul_e(a2, 4'd2) ^ mul_e(a3, 4'd3);
        m[4 * c + 3] = mul_e(a0, 4'd3) ^ a1 ^ a2 ^ mul_e(a3, 4'd2);
      end else begin
        m[4 * c]     = mul_e(a0, 4'd14) ^ mul_e(a1, 4'd11) ^ mul_e(a2, 4'd13)
                       ^ mul_e(a3, 4'd9);
        m[4 * c + 1] = mul_e(a0, 4'd9) ^ mul_e(a1, 4'd14) ^ mul_e(a2, 4'd11)
                       ^ mul_e(a3, 4'd13);
        m[4 * c + 2] = mul_e(a0, 4'd13) ^ mul_e(a1, 4'd9) ^ mul_e(a2, 4'd14)
                       ^ mul_e(a3, 4'd11);
        m[4 * c + 3] = mul_e(a0, 4'd11) ^ mul_e(a1, 4'd13) ^ mul_e(a2, 4'd9)
                       ^ mul_e(a3, 4'd14);
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (ctl.enc) begin
        state_out[127 - 8 * i -: 8] = (ctl.skip_mix ? o[i] : m[i])
                                      ^ round_key[127 - 8 * i -: 8];
      end else begin
        state_out[127 - 8 * i -: 8] = ctl.skip_mix ? o[i] : m[i];
      end
    end
  end

endmodule

// ===== rtl/aes128_cbc_ctr_decryptor.sv =====
// top level: aes-128 cbc / ctr decryptor with a shared round unit and sequencer
//
// a word with tuser 0 loads the iv (cbc) or initial counter (ctr) and gives no
// result. a ciphertext word (tuser 1) goes through these steps before its
// result is registered: acceptance, expansion of the key schedule
// through the single key-step unit into an eleven-entry round key
// store, ten passes of the one shared round unit, and forming the
// plaintext and updating the chaining value. the input is not ready from
// acceptance until the result has been loaded into the output register; a
// result waiting on the output side holds the sequencer in its final step.
// configuration (mode, key halves) is taken by a plain write port at any edge
// with cfg_we high and should only be written while the block is idle.
module aes128_cbc_ctr_decryptor (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,  // block_high, block_low, valid_bytes, zero pad
  input  logic         s_tuser,  // action
  input  logic         s_tlast,  // last_block
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,  // plain_high, plain_low, out_valid_bytes,
                                 // strip_count, zero pad
  output logic         m_tlast   // final_out
);

  localparam int StepW = aescd_pkg::StepW;
  localparam logic [StepW-1:0] LastRound = StepW'(aescd_pkg::NumRounds);

  // configuration registers
  logic        cipher_mode;
  logic [63:0] key_high, key_low;

  // sequencer and datapath registers
  aescd_pkg::state_t state, state_next;
  logic [StepW-1:0]  step;
  logic [7:0]        rcon;
  logic [127:0]      kreg;
  logic [127:0]      st;
  logic [127:0]      blk;
  logic [4:0]        vb;
  logic              last;
  logic [127:0]      chain;
  logic [127:0]      rk [aescd_pkg::NumRounds + 1];  // no reset, written per block

  logic [127:0] key_next, round_out, rkey;
  aescd_pkg::round_ctl_t ctl;
  logic accept, out_load, rounds_done;
  logic [127:0] plain, ctr_x;
  logic [4:0]   vb_sat;
  logic [7:0]   strip;

  assign accept = s_tvalid && s_tready;
  assign rkey   = rk[step];
  assign ctl.enc      = cipher_mode;
  assign ctl.skip_mix = cipher_mode ? (step == LastRound) : (step == '0);
  assign rounds_done  = ctl.skip_mix;

  aescd_key_step u_key_step (
    .key_in  (kreg),
    .rcon    (rcon),
    .key_out (key_next)
  );

  aescd_round u_round (
    .state_in  (st),
    .round_key (rkey),
    .ctl       (ctl),
    .state_out (round_out)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      aescd_pkg::ST_IDLE: begin
        if (accept && s_tuser != aescd_pkg::ACT_LOAD) state_next = aescd_pkg::ST_EXPAND;
      end
      aescd_pkg::ST_EXPAND: begin
        if (step == LastRound) state_next = aescd_pkg::ST_ROUNDS;
      end
      aescd_pkg::ST_ROUNDS: begin
        if (rounds_done) state_next = aescd_pkg::ST_OUT;
      end
      aescd_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) state_next = aescd_pkg::ST_IDLE;
      end
      default: state_next = aescd_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs of the sequencer
  always_comb begin
    s_tready = (state == aescd_pkg::ST_IDLE);
    out_load = (state == aescd_pkg::ST_OUT) && (!m_tvalid || m_tready);
  end

  // result forming: cbc xors with the previous block, ctr masks past the count
  always_comb begin
    vb_sat = (vb > 5'd16) ? 5'd16 : vb;
    ctr_x  = st ^ blk;
    strip  = 8'h00;
    if (cipher_mode == aescd_pkg::MODE_CBC) begin
      plain  = st ^ chain;
      vb_sat = 5'd16;
      if (last) strip = plain[7:0];
    end else begin
      for (int i = 0; i < 16; i++) begin
        plain[127 - 8 * i -: 8] = (5'(i) < vb_sat) ? ctr_x[127 - 8 * i -: 8] : 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= aescd_pkg::ST_IDLE;
      cipher_mode <= 1'b0;
      key_high    <= '0;
      key_low     <= '0;
      chain       <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          aescd_pkg::CFG_MODE:     cipher_mode <= cfg_data[0];
          aescd_pkg::CFG_KEY_HIGH: key_high    <= cfg_data;
          aescd_pkg::CFG_KEY_LOW:  key_low     <= cfg_data;
          default: ;
        endcase
      end
      if (accept && s_tuser == aescd_pkg::ACT_LOAD) begin
        chain <= {s_tdata[63:0], s_tdata[127:64]};
      end
      if (out_load) begin
        if (cipher_mode == aescd_pkg::MODE_CBC) begin
          chain <= blk;
        end else begin
          chain <= chain + 128'd1;
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      aescd_pkg::ST_IDLE: begin
        if (accept) begin
          blk   <= {s_tdata[63:0], s_tdata[127:64]};
          vb    <= s_tdata[132:128];
          last  <= s_tlast;
          kreg  <= {key_high, key_low};
          rk[0] <= {key_high, key_low};
          rcon  <= 8'h01;
          step  <= StepW'(1);
          st    <= (cipher_mode == aescd_pkg::MODE_CBC)
                   ? {s_tdata[63:0], s_tdata[127:64]}
                   : chain ^ {key_high, key_low};
        end
      end
      aescd_pkg::ST_EXPAND: begin
        kreg     <= key_next;
        rk[step] <= key_next;
        rcon     <= aescd_pkg::xt(rcon);
        if (step == LastRound) begin
          // decryption opens with the last round key
          if (cipher_mode == aescd_pkg::MODE_CBC) begin
            st   <= st ^ key_next;
            step <= LastRound - StepW'(1);
          end else begin
            step <= StepW'(1);
          end
        end else begin
          step <= step + StepW'(1);
        end
      end
      aescd_pkg::ST_ROUNDS: begin
        st <= round_out;
        if (!rounds_done) begin
          step <= cipher_mode ? step + StepW'(1) : step - StepW'(1);
        end
      end
      aescd_pkg::ST_OUT: begin
        if (out_load) begin
          m_tdata <= {3'b000, strip, vb_sat, plain[63:0], plain[127:64]};
          m_tlast <= last;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/aescd_checker.sv =====
// port-level checks for the decryptor, bound to the top level
module aescd_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [143:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a ciphertext word occupies the block
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("ready after ciphertext word");

  // a load word gives no result and keeps the input open
  a_load: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> s_tready)
    else $error("not ready after load word");

  // no result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind aes128_cbc_ctr_decryptor aescd_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== verif/testbench.sv =====
// self-checking testbench for the aes-128 cbc / ctr decryptor
module testbench;

  localparam logic       ACT_BLOCK  = ~aescd_pkg::ACT_LOAD;
  localparam logic       MODE_CTR   = ~aescd_pkg::MODE_CBC;
  // an index past the last register, which the block must ignore
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int         WATCHDOG_LIMIT = 20000;
  // settling time that covers any work still in flight
  localparam int         SETTLE_CYCLES  = 40;
  localparam int         RANDOM_ITEMS   = 430;

  typedef struct packed {
    logic [63:0] plain_hi;
    logic [63:0] plain_lo;
    logic [4:0]  nbytes;
    logic [7:0]  strip;
    logic        fin;
  } plain_word_t;

  typedef struct {
    logic        is_cfg;
    logic [1:0]  cfg_idx;
    logic [63:0] cfg_val;
    logic        act;
    logic [63:0] blk_hi;
    logic [63:0] blk_lo;
    logic [4:0]  nbytes;
    logic        last;
    logic        typed;   // expected word written into the row by hand
    plain_word_t want;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;  // block_high, block_low, valid_bytes, zero pad
  logic         s_tuser = 1'b0;  // action
  logic         s_tlast = 1'b0;  // last_block
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;  // plain_high, plain_low, out_valid_bytes, strip_count, pad
  logic         m_tlast;  // final_out

  // predictor state: mirror of the registers and the chaining value
  logic         mode_q;
  logic [63:0]  key_hi_q, key_lo_q;
  logic [127:0] chain_q;
  logic [127:0] round_key [11];

  plain_word_t  pending_plain[$];
  stim_row_t    directed[$];
  int           s_idle, r_idle;
  int           mismatches = 0;
  int           words_in = 0, words_out = 0, cfg_writes = 0;
  int           quiet_cycles = 0;

  aes128_cbc_ctr_decryptor dut (.*);

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- aes model
  // byte i of a 128-bit block sits at bits 127-8i downwards (byte 0 first)

  function automatic logic [7:0] times_x(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = times_x(a);
    end
    return acc;
  endfunction

  function automatic logic [127:0] sub_all(input logic [127:0] v, input logic inv);
    logic [127:0] o;
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = inv ? aescd_pkg::INV_SBOX[v[127-8*i -: 8]]
                            : aescd_pkg::SBOX[v[127-8*i -: 8]];
    end
    return o;
  endfunction

  // row r, column c is byte r + 4c
  function automatic logic [127:0] rotate_rows(input logic [127:0] v, input logic fwd);
    logic [127:0] o;
    int src;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = fwd ? r + 4 * ((c + r) & 3) : r + 4 * ((c - r + 4) & 3);
        o[127-8*(r+4*c) -: 8] = v[127-8*src -: 8];
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_all(input logic [127:0] v, input logic fwd);
    logic [127:0] o;
    logic [7:0]   a [4];
    logic [7:0]   m [4];
    if (fwd) begin
      m[0] = 8'd2; m[1] = 8'd3; m[2] = 8'd1; m[3] = 8'd1;
    end else begin
      m[0] = 8'd14; m[1] = 8'd11; m[2] = 8'd13; m[3] = 8'd9;
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = v[127-8*(4*c+r) -: 8];
      for (int r = 0; r < 4; r++) begin
        o[127-8*(4*c+r) -: 8] = gf_mul(a[0], m[(4-r)&3]) ^ gf_mul(a[1], m[(5-r)&3]) ^
                                gf_mul(a[2], m[(6-r)&3]) ^ gf_mul(a[3], m[(7-r)&3]);
      end
    end
    return o;
  endfunction

  function automatic void expand_schedule();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    {w[0], w[1], w[2], w[3]} = {key_hi_q, key_lo_q};
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {aescd_pkg::SBOX[t[23:16]] ^ rc, aescd_pkg::SBOX[t[15:8]],
             aescd_pkg::SBOX[t[7:0]], aescd_pkg::SBOX[t[31:24]]};
        rc = times_x(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) round_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic logic [127:0] encipher(input logic [127:0] v);
    v ^= round_key[0];
    for (int r = 1; r <= 10; r++) begin
      v = rotate_rows(sub_all(v, 1'b0), 1'b1);
      if (r != 10) v = mix_all(v, 1'b1);
      v ^= round_key[r];
    end
    return v;
  endfunction

  function automatic logic [127:0] decipher(input logic [127:0] v);
    v ^= round_key[10];
    for (int r = 9; r >= 0; r--) begin
      v = sub_all(rotate_rows(v, 1'b0), 1'b1) ^ round_key[r];
      if (r != 0) v = mix_all(v, 1'b0);
    end
    return v;
  endfunction

  // works out the plaintext word of one accepted input word and advances the chain
  function automatic logic predict_plain(input logic act, input logic [127:0] blk,
                                         input logic [4:0] nb, input logic last,
                                         output plain_word_t res);
    logic [127:0] p;
    logic [4:0]   cnt;
    res = '0;
    if (act == aescd_pkg::ACT_LOAD) begin
      chain_q = blk;
      return 1'b0;
    end
    if (mode_q == aescd_pkg::MODE_CBC) begin
      p = decipher(blk) ^ chain_q;
      chain_q = blk;
      cnt = 5'd16;
      res.strip = last ? p[7:0] : 8'h00;
    end else begin
      p = encipher(chain_q) ^ blk;
      cnt = (nb > 5'd16) ? 5'd16 : nb;
      // bytes past the valid count are cleared
      for (int i = 0; i < 16; i++) if (i >= cnt) p[127-8*i -: 8] = 8'h00;
      chain_q = chain_q + 128'd1;  // big-endian counter, wraps to zero
    end
    {res.plain_hi, res.plain_lo} = p;
    res.nbytes = cnt;
    res.fin = last;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic settle_and_write(input logic [1:0] idx, input logic [63:0] val);
    s_tvalid <= 1'b0;
    while (pending_plain.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    case (idx)
      aescd_pkg::CFG_MODE:     mode_q = val[0];
      aescd_pkg::CFG_KEY_HIGH: key_hi_q = val;
      aescd_pkg::CFG_KEY_LOW:  key_lo_q = val;
      default: ;
    endcase
    expand_schedule();
  endtask

  task automatic send_word(input logic act, input logic [63:0] hi, input logic [63:0] lo,
                           input logic [4:0] nb, input logic last, input logic typed,
                           input plain_word_t want);
    plain_word_t res;
    while ($urandom_range(99) < s_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tlast <= last;
    s_tdata <= {3'b000, nb, lo, hi};
    do @(posedge clk); while (!s_tready);
    words_in++;
    if (predict_plain(act, {hi, lo}, nb, last, res)) begin
      pending_plain.push_back(typed ? want : res);
    end
  endtask

  task automatic push_cfg(input logic [1:0] idx, input logic [63:0] val);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    directed.push_back(r);
  endtask

  task automatic push_item(input logic act, input logic [127:0] blk, input logic [4:0] nb,
                           input logic last, input logic typed, input plain_word_t want);
    stim_row_t r;
    r = '{default: '0};
    r.act = act;
    {r.blk_hi, r.blk_lo} = blk;
    r.nbytes = nb;
    r.last = last;
    r.typed = typed;
    r.want = want;
    directed.push_back(r);
  endtask

  // one message: usually a load then a run of blocks, sometimes plain noise
  task automatic random_message(ref int budget);
    int          nblk;
    logic [127:0] blk;
    logic [4:0]  nb;
    if ($urandom_range(9) == 0) begin
      send_word(1'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                5'($urandom), 1'($urandom), 1'b0, '0);
      budget--;
      return;
    end
    send_word(aescd_pkg::ACT_LOAD, {$urandom, $urandom}, {$urandom, $urandom},
              5'($urandom), 1'($urandom), 1'b0, '0);
    budget--;
    nblk = $urandom_range(6, 1);
    for (int b = 0; b < nblk; b++) begin
      blk = {$urandom, $urandom, $urandom, $urandom};
      // partial counts mostly on the final block, a few in the middle
      nb = (b == nblk - 1 || $urandom_range(9) == 0) ? 5'($urandom) : 5'd16;
      send_word(ACT_BLOCK, blk[127:64], blk[63:0], nb, b == nblk - 1, 1'b0, '0);
      budget--;
    end
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    plain_word_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      words_out++;
      got = {m_tdata[63:0], m_tdata[127:64], m_tdata[132:128], m_tdata[140:133], m_tlast};
      if (pending_plain.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %h", got);
      end else begin
        want = pending_plain.pop_front();
        if (got.plain_hi !== want.plain_hi || got.plain_lo !== want.plain_lo ||
            got.nbytes !== want.nbytes || got.strip !== want.strip || got.fin !== want.fin) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: plain %h_%h bytes %0d strip %h last %b",
                     got.plain_hi, got.plain_lo, got.nbytes, got.strip, got.fin);
            $display("  wanted: plain %h_%h bytes %0d strip %h last %b",
                     want.plain_hi, want.plain_lo, want.nbytes, want.strip, want.fin);
          end
        end
      end
    end
    m_tready <= ($urandom_range(99) >= r_idle);
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress, %0d words still expected", pending_plain.size());
      $display("testbench failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    plain_word_t want;
    int          budget;
    mode_q = aescd_pkg::MODE_CBC;
    key_hi_q = '0;
    key_lo_q = '0;
    chain_q = '0;
    expand_schedule();
    s_idle = 29;
    r_idle = 68;

    // directed part: published cbc and ctr vectors plus the corner cases
    // no load before the first block: chaining starts from zero, key all zeros
    push_item(ACT_BLOCK, '0, 5'd16, 1'b1, 1'b0, '0);
    push_cfg(aescd_pkg::CFG_KEY_HIGH, 64'h2b7e151628aed2a6);
    push_cfg(aescd_pkg::CFG_KEY_LOW, 64'habf7158809cf4f3c);
    push_item(aescd_pkg::ACT_LOAD, 128'h000102030405060708090a0b0c0d0e0f, 5'd0, 1'b0,
              1'b0, '0);
    want = '{64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 8'h00, 1'b0};
    // cbc ignores the valid count, even zero
    push_item(ACT_BLOCK, 128'h7649abac8119b246cee98e9b12e9197d, 5'd0, 1'b0, 1'b1, want);
    push_item(ACT_BLOCK, 128'h5086cb9b507219ee95db113a917678b2, 5'd31, 1'b1, 1'b0, '0);
    // block after the final one with no new load keeps chaining
    push_item(ACT_BLOCK, {128{1'b1}}, 5'd7, 1'b1, 1'b0, '0);
    push_cfg(aescd_pkg::CFG_MODE, 64'(MODE_CTR));
    push_item(aescd_pkg::ACT_LOAD, 128'hf0f1f2f3f4f5f6f7f8f9fafbfcfdfeff, 5'd16, 1'b1,
              1'b0, '0);
    want = '{64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 8'h00, 1'b0};
    push_item(ACT_BLOCK, 128'h874d6191b620e3261bef6864990db6ce, 5'd16, 1'b0, 1'b1, want);
    push_item(ACT_BLOCK, 128'h9806f66b7970fdff8617187bb9fffdff, 5'd16, 1'b0, 1'b0, '0);
    // count zero clears every byte
    want = '{64'h0, 64'h0, 5'd0, 8'h00, 1'b0};
    push_item(ACT_BLOCK, {128{1'b1}}, 5'd0, 1'b0, 1'b1, want);
    // partial block in mid message still advances the counter
    push_item(ACT_BLOCK, 128'h0123456789abcdeffedcba9876543210, 5'd5, 1'b0, 1'b0, '0);
    // count above sixteen saturates
    push_item(ACT_BLOCK, {128{1'b1}}, 5'd31, 1'b0, 1'b0, '0);
    push_item(ACT_BLOCK, '0, 5'd15, 1'b1, 1'b0, '0);
    // counter wrap from all ones to zero, then the low half carrying up
    push_item(aescd_pkg::ACT_LOAD, {128{1'b1}}, 5'd0, 1'b0, 1'b0, '0);
    push_item(ACT_BLOCK, '0, 5'd16, 1'b0, 1'b0, '0);
    push_item(ACT_BLOCK, '0, 5'd1, 1'b1, 1'b0, '0);
    push_item(aescd_pkg::ACT_LOAD, 128'h0000000000000000ffffffffffffffff, 5'd16, 1'b0,
              1'b0, '0);
    push_item(ACT_BLOCK, {128{1'b1}}, 5'd16, 1'b0, 1'b0, '0);
    push_item(ACT_BLOCK, {128{1'b1}}, 5'd16, 1'b1, 1'b0, '0);
    // write to an unused index is ignored
    push_cfg(CFG_UNUSED, {64{1'b1}});
    push_cfg(aescd_pkg::CFG_KEY_HIGH, {64{1'b1}});
    push_cfg(aescd_pkg::CFG_KEY_LOW, {64{1'b1}});
    push_item(aescd_pkg::ACT_LOAD, '0, 5'd16, 1'b0, 1'b0, '0);
    push_item(ACT_BLOCK, 128'h8000000000000001_8000000000000001, 5'd16, 1'b1, 1'b0, '0);
    push_cfg(aescd_pkg::CFG_MODE, 64'(aescd_pkg::MODE_CBC));
    push_item(aescd_pkg::ACT_LOAD, {128{1'b1}}, 5'd31, 1'b1, 1'b0, '0);
    push_item(ACT_BLOCK, '0, 5'd16, 1'b1, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        settle_and_write(directed[i].cfg_idx, directed[i].cfg_val);
      end else begin
        send_word(directed[i].act, directed[i].blk_hi, directed[i].blk_lo,
                  directed[i].nbytes, directed[i].last, directed[i].typed, directed[i].want);
      end
    end

    // random part in three idling phases, with the key and mode changed between runs
    for (int ph = 0; ph < 3; ph++) begin
      s_idle = (ph == 0) ? 29 : (ph == 1) ? 68 : 0;
      r_idle = (ph == 0) ? 68 : (ph == 1) ? 29 : 0;
      budget = RANDOM_ITEMS;
      while (budget > 0) begin
        if ($urandom_range(7) == 0) begin
          case ($urandom_range(3))
            0: settle_and_write(aescd_pkg::CFG_KEY_HIGH, {64{1'b0}});
            1: settle_and_write(aescd_pkg::CFG_KEY_LOW, {64{1'b1}});
            default: settle_and_write(2'($urandom), {$urandom, $urandom});
          endcase
          settle_and_write(aescd_pkg::CFG_MODE, 64'($urandom));
        end
        random_message(budget);
      end
    end
    s_tvalid <= 1'b0;

    while (pending_plain.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d words sent, %0d plaintext words checked, %0d register writes",
             words_in, words_out, cfg_writes);
    $display("cbc and ctr runs under three idling patterns, %0d mismatches", mismatches);
    if (mismatches == 0 && pending_plain.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/aescd_pkg.sv
rtl/aescd_key_step.sv
rtl/aescd_round.sv
rtl/aes128_cbc_ctr_decryptor.sv
rtl/aescd_checker.sv
verif/testbench.sv
